### sv/lcd_two_wire_shift_writer_core_defines.svh
// assertion helpers shared by the writer rtl
`ifndef LCD_TWO_WIRE_SHIFT_WRITER_CORE_DEFINES_SVH
`define LCD_TWO_WIRE_SHIFT_WRITER_CORE_DEFINES_SVH

// condition must hold at every edge out of reset
`define LCDSW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent on the same edge
`define LCDSW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent on the next edge
`define LCDSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lcdsw_pkg.sv
package lcdsw_pkg;

    localparam int STEP_W = 6;

    // request codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_BYTE    = 3'd1;
    localparam logic [2:0] CMD_CHAR    = 3'd2;
    localparam logic [2:0] CMD_POS     = 3'd3;
    localparam logic [2:0] CMD_CHAR_AT = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_STEP_TICKS        = 2'd0;
    localparam logic [1:0] REG_CMD_SETTLE_TICKS  = 2'd1;
    localparam logic [1:0] REG_DATA_SETTLE_STEPS = 2'd2;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 6'd0;
    localparam logic [STEP_W-1:0] FIRST_CHANGE = 6'd1;
    localparam logic [STEP_W-1:0] LAST_CHANGE = 6'd33;
    localparam logic [STEP_W-1:0] GAP_PHASE   = 6'd34;

    localparam logic [7:0] ROW_BASE_0 = 8'h80;
    localparam logic [7:0] ROW_BASE_1 = 8'hC0;
    localparam logic [7:0] ROW_BASE_2 = 8'h94;
    localparam logic [7:0] ROW_BASE_3 = 8'hD4;

    typedef struct packed {
        logic clk;
        logic data;
    } pins_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              nibble_select;
        logic              select_bit;
        logic [7:0]        byte_held;
    } pin_ctl_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = ROW_BASE_0;
            2'd1:    base = ROW_BASE_1;
            2'd2:    base = ROW_BASE_2;
            default: base = ROW_BASE_3;
        endcase
        return base;
    endfunction

endpackage

### sv/lcdsw_pin_seq.sv
module lcdsw_pin_seq (
    input  lcdsw_pkg::pin_ctl_t ctl,
    input  lcdsw_pkg::pins_t    pins_cur,
    output lcdsw_pkg::pins_t    pins_new
);
    import lcdsw_pkg::*;

    logic [3:0] nib;

    assign nib = ctl.nibble_select ? ctl.byte_held[3:0] : ctl.byte_held[7:4];

    always_comb
    begin
        pins_new = pins_cur;
        case (ctl.step) inside
            6'd1:                      pins_new.data = 1'b0;
            // six clear pulses: even steps raise clk, odd steps drop it
            [6'd2:6'd13]:              pins_new.clk  = ~ctl.step[0];
            6'd14:                     pins_new.data = 1'b1;
            6'd15, 6'd18:              pins_new.clk  = 1'b1;
            6'd16, 6'd19:              pins_new.clk  = 1'b0;
            6'd17:                     pins_new.data = ctl.select_bit;
            6'd20:                     pins_new.data = nib[3];
            6'd23:                     pins_new.data = nib[2];
            6'd26:                     pins_new.data = nib[1];
            6'd29:                     pins_new.data = nib[0];
            6'd21, 6'd24, 6'd27, 6'd30: pins_new.clk  = 1'b1;
            6'd22, 6'd25, 6'd28, 6'd31: pins_new.clk  = 1'b0;
            6'd32:                     pins_new.data = 1'b1;
            default:                   pins_new.data = 1'b0;
        endcase
    end

endmodule

### sv/lcd_two_wire_shift_writer_core.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | cmd, value, row, col
// out     | output    | out_valid / out_stall| data_pin, clk_pin, busy_res, rejected
// cfg     | input     | wr_en                | wr_index, wr_data
//
// one beat in, one beat out; a new beat is taken every cycle while in_stall is low
// each in beat is one tick: the whole pin step is computed combinationally into the out register
// a pin change holds step_ticks beats (one if zero), settle waits share the tick counter
// in_stall is high only while a finished out beat is held by out_stall
// rst_n clears the sequencer to idle with both pins low and loads register defaults

`include "lcd_two_wire_shift_writer_core_defines.svh"

module lcd_two_wire_shift_writer_core #(
    parameter int unsigned WAIT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [7:0]  value,
    input  logic [2:0]  row,
    input  logic [7:0]  col,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        data_pin,
    output logic        clk_pin,
    output logic        busy_res,
    output logic        rejected
);
    import lcdsw_pkg::*;

    localparam int LEN_W = 16;

    logic [7:0]           step_ticks_reg;
    logic [15:0]          cmd_settle_ticks_reg;
    logic [3:0]           data_settle_steps_reg;

    logic [STEP_W-1:0]    step_index_reg, step_index_next;
    logic                 nibble_select_reg, nibble_select_next;
    logic [7:0]           byte_held_reg, byte_held_next;
    logic                 select_bit_reg, select_bit_next;
    logic                 char_pending_reg, char_pending_next;
    logic [7:0]           char_held_reg, char_held_next;
    logic [WAIT_BITS-1:0] wait_count_reg, wait_count_next;
    pins_t                pins_reg, pins_next, pins_applied;

    logic                 out_valid_reg;
    logic                 data_pin_reg, clk_pin_reg, busy_res_reg, rejected_reg;

    logic                 accept_in;
    logic                 req;
    logic                 busy;
    logic                 rej;
    logic                 do_adv;
    logic                 do_leave;
    logic                 do_start;
    logic                 enter;
    logic [7:0]           start_byte;
    logic                 start_sel;
    logic [7:0]           pos_byte;
    logic [7:0]           step_len;
    logic [11:0]          data_len;
    logic [LEN_W-1:0]     gap_len;
    logic                 gap_sat;
    logic [WAIT_BITS-1:0] gap_wait;
    logic [WAIT_BITS-1:0] step_wait;
    pin_ctl_t             pin_ctl;

    assign in_stall  = out_valid_reg & out_stall;
    assign accept_in = in_valid & ~in_stall;

    assign busy     = (step_index_reg != STEP_IDLE);
    assign pos_byte = row_base(row[1:0]) + col;

    // zero step length runs as one tick
    assign step_len  = (step_ticks_reg == 8'd0) ? 8'd1 : step_ticks_reg;
    assign step_wait = WAIT_BITS'(step_len - 8'd1);
    assign data_len  = 12'(data_settle_steps_reg) * 12'(step_len);

    always_comb
    begin
        if (!nibble_select_reg)
            gap_len = LEN_W'(step_len);
        else if (!select_bit_reg)
            gap_len = cmd_settle_ticks_reg;
        else
            gap_len = LEN_W'(data_len);
    end

    assign gap_sat  = (WAIT_BITS < LEN_W) && ((gap_len >> WAIT_BITS) != '0);
    assign gap_wait = gap_sat ? '1 : WAIT_BITS'(gap_len);

    always_comb
    begin
        step_index_next    = step_index_reg;
        nibble_select_next = nibble_select_reg;
        byte_held_next     = byte_held_reg;
        select_bit_next    = select_bit_reg;
        char_pending_next  = char_pending_reg;
        char_held_next     = char_held_reg;
        wait_count_next    = wait_count_reg;
        req        = cmd inside {[CMD_BYTE:CMD_CHAR_AT]};
        rej        = 1'b0;
        do_adv     = 1'b0;
        do_leave   = 1'b0;
        do_start   = 1'b0;
        enter      = 1'b0;
        start_byte = value;
        start_sel  = 1'b0;

        if (req && busy)
        begin
            rej    = 1'b1;
            do_adv = 1'b1;
        end
        else if (req)
        begin
            case (cmd)
                CMD_BYTE:
                begin
                    char_pending_next = 1'b0;
                    do_start          = 1'b1;
                end
                CMD_CHAR:
                begin
                    char_pending_next = 1'b0;
                    do_start          = 1'b1;
                    start_sel         = 1'b1;
                end
                CMD_POS:
                begin
                    if (row <= 3'd3)
                    begin
                        char_pending_next = 1'b0;
                        do_start          = 1'b1;
                        start_byte        = pos_byte;
                    end
                end
                default:
                begin
                    char_held_next = value;
                    do_start       = 1'b1;
                    if (row <= 3'd3)
                    begin
                        char_pending_next = 1'b1;
                        start_byte        = pos_byte;
                    end
                    else
                    begin
                        // bad row: character goes out at the current cursor
                        char_pending_next = 1'b0;
                        start_sel         = 1'b1;
                    end
                end
            endcase
        end
        else
        begin
            do_adv = 1'b1;
        end

        if (do_start)
        begin
            byte_held_next     = start_byte;
            select_bit_next    = start_sel;
            nibble_select_next = 1'b0;
            step_index_next    = FIRST_CHANGE;
            enter              = 1'b1;
        end

        if (do_adv && busy)
        begin
            if (wait_count_reg != '0)
                wait_count_next = wait_count_reg - 1'b1;
            else if (step_index_reg < LAST_CHANGE)
            begin
                step_index_next = step_index_reg + 1'b1;
                enter           = 1'b1;
            end
            else if (step_index_reg == LAST_CHANGE)
            begin
                step_index_next = GAP_PHASE;
                if (gap_len == '0)
                    do_leave = 1'b1;
                else
                    wait_count_next = gap_wait - 1'b1;
            end
            else
                do_leave = 1'b1;
        end

        if (do_leave)
        begin
            if (!nibble_select_reg)
            begin
                nibble_select_next = 1'b1;
                step_index_next    = FIRST_CHANGE;
                enter              = 1'b1;
            end
            else if (char_pending_reg)
            begin
                char_pending_next  = 1'b0;
                byte_held_next     = char_held_reg;
                select_bit_next    = 1'b1;
                nibble_select_next = 1'b0;
                step_index_next    = FIRST_CHANGE;
                enter              = 1'b1;
            end
            else
            begin
                step_index_next    = STEP_IDLE;
                nibble_select_next = 1'b0;
                wait_count_next    = '0;
            end
        end

        if (enter)
            wait_count_next = step_wait;
    end

    assign pin_ctl = '{
        step:          step_index_next,
        nibble_select: nibble_select_next,
        select_bit:    select_bit_next,
        byte_held:     byte_held_next
    };

    lcdsw_pin_seq u_pin_seq (
        .ctl      (pin_ctl),
        .pins_cur (pins_reg),
        .pins_new (pins_applied)
    );

    assign pins_next = enter ? pins_applied : pins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ticks_reg        <= 8'd1;
            cmd_settle_ticks_reg  <= 16'd5000;
            data_settle_steps_reg <= 4'd2;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_STEP_TICKS:        step_ticks_reg        <= wr_data[7:0];
                REG_CMD_SETTLE_TICKS:  cmd_settle_ticks_reg  <= wr_data;
                REG_DATA_SETTLE_STEPS: data_settle_steps_reg <= wr_data[3:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_index_reg    <= STEP_IDLE;
            nibble_select_reg <= 1'b0;
            byte_held_reg     <= 8'd0;
            select_bit_reg    <= 1'b0;
            char_pending_reg  <= 1'b0;
            char_held_reg     <= 8'd0;
            wait_count_reg    <= '0;
            pins_reg          <= '0;
        end
        else if (accept_in)
        begin
            step_index_reg    <= step_index_next;
            nibble_select_reg <= nibble_select_next;
            byte_held_reg     <= byte_held_next;
            select_bit_reg    <= select_bit_next;
            char_pending_reg  <= char_pending_next;
            char_held_reg     <= char_held_next;
            wait_count_reg    <= wait_count_next;
            pins_reg          <= pins_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept_in)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // out beat payload
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            data_pin_reg <= pins_next.data;
            clk_pin_reg  <= pins_next.clk;
            busy_res_reg <= (step_index_next != STEP_IDLE);
            rejected_reg <= rej;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_pin  = data_pin_reg;
    assign clk_pin   = clk_pin_reg;
    assign busy_res  = busy_res_reg;
    assign rejected  = rejected_reg;

    `LCDSW_ASSERT_ALWAYS(a_step_range, step_index_reg <= GAP_PHASE, "step index out of range")
    `LCDSW_ASSERT_IMPLY(a_idle_clean, step_index_reg == STEP_IDLE, (wait_count_reg == '0) && !nibble_select_reg, "idle with leftover wait or nibble")
    `LCDSW_ASSERT_IMPLY(a_pending_pos, char_pending_reg, !select_bit_reg && (step_index_reg != STEP_IDLE), "pending char outside a position byte")
    `LCDSW_ASSERT_NEXT(a_idle_tick_pins, accept_in && (step_index_reg == STEP_IDLE) && !req, pins_reg == $past(pins_reg), "pins moved on an idle tick")

endmodule
